// ===== hdl/bmidi_pkg.sv =====
// Shared types, status byte codes and the message length lookup for the BLE MIDI decoder.
// Used by bmidi_parser and ble_midi_packet_decoder. No dependencies.
package bmidi_pkg;

    localparam int BYTE_W  = 8;
    localparam int DATA_W  = 7;
    localparam int COUNT_W = 2;
    localparam int TS_W    = 64;

    localparam logic [BYTE_W-1:0] ST_CHANNEL_BASE = 8'h80;
    localparam logic [BYTE_W-1:0] ST_CTRL_CHANGE  = 8'hb0;
    localparam logic [BYTE_W-1:0] ST_PROG_CHANGE  = 8'hc0;
    localparam logic [BYTE_W-1:0] ST_CHAN_PRESS   = 8'hd0;
    localparam logic [BYTE_W-1:0] ST_PITCH_BEND   = 8'he0;
    localparam logic [BYTE_W-1:0] ST_SYSEX_START  = 8'hf0;
    localparam logic [BYTE_W-1:0] ST_TIME_CODE    = 8'hf1;
    localparam logic [BYTE_W-1:0] ST_SONG_POS     = 8'hf2;
    localparam logic [BYTE_W-1:0] ST_SONG_SELECT  = 8'hf3;
    localparam logic [BYTE_W-1:0] ST_SYSEX_END    = 8'hf7;
    localparam logic [BYTE_W-1:0] ST_REALTIME     = 8'hf8;
    localparam logic [BYTE_W-1:0] CMD_MASK        = 8'hf0;

    typedef struct packed {
        logic [BYTE_W-1:0]  status;
        logic [DATA_W-1:0]  data1;
        logic [DATA_W-1:0]  data2;
        logic [COUNT_W-1:0] count;
        logic [TS_W-1:0]    timestamp;
    } t_msg;

    // Number of data bytes that follow a status byte.
    function automatic logic [COUNT_W-1:0] length_of(input logic [BYTE_W-1:0] st);
        logic [BYTE_W-1:0]  cmd;
        logic [COUNT_W-1:0] len;
        cmd = st & CMD_MASK;
        len = 2'd0;
        if (cmd >= ST_CHANNEL_BASE && cmd <= ST_CTRL_CHANGE) begin
            len = 2'd2;
        end else if (cmd == ST_PROG_CHANGE || cmd == ST_CHAN_PRESS) begin
            len = 2'd1;
        end else if (cmd == ST_PITCH_BEND) begin
            len = 2'd2;
        end else if (st == ST_TIME_CODE || st == ST_SONG_SELECT) begin
            len = 2'd1;
        end else if (st == ST_SONG_POS) begin
            len = 2'd2;
        end
        return len;
    endfunction

endpackage

// ===== hdl/bmidi_parser.sv =====
// Packet parse state machine: takes one byte per step, reports a finished message.
// Depends on bmidi_pkg.
module bmidi_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [bmidi_pkg::BYTE_W-1:0]  i_byte,
    input  logic                          i_first,
    input  logic [bmidi_pkg::TS_W-1:0]    i_timestamp,
    output logic                          o_emit,
    output bmidi_pkg::t_msg               o_msg
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TIME,
        PH_STATUS,
        PH_DATA
    } t_phase;

    t_phase                           r_phase, n_phase;
    logic [bmidi_pkg::BYTE_W-1:0]     r_running, n_running;
    logic                             r_in_sysex, n_in_sysex;
    logic [bmidi_pkg::BYTE_W-1:0]     r_current, n_current;
    logic [bmidi_pkg::COUNT_W-1:0]    r_needed, n_needed;
    logic                             r_taken, n_taken;
    logic [bmidi_pkg::DATA_W-1:0]     r_hold, n_hold;
    logic [bmidi_pkg::TS_W-1:0]       r_packet_time, n_packet_time;

    logic                             high;
    logic [bmidi_pkg::COUNT_W-1:0]    len_byte;
    logic [bmidi_pkg::COUNT_W-1:0]    len_running;

    assign high        = i_byte[bmidi_pkg::BYTE_W-1];
    assign len_byte    = bmidi_pkg::length_of(i_byte);
    assign len_running = bmidi_pkg::length_of(r_running);

    always_comb begin
        n_phase       = r_phase;
        n_running     = r_running;
        n_in_sysex    = r_in_sysex;
        n_current     = r_current;
        n_needed      = r_needed;
        n_taken       = r_taken;
        n_hold        = r_hold;
        n_packet_time = r_packet_time;
        o_emit        = 1'b0;
        o_msg         = '0;
        o_msg.timestamp = r_packet_time;

        if (i_first) begin
            // New header: drop any unfinished message, keep running status and SysEx flag.
            n_taken = 1'b0;
            n_hold  = '0;
            if (high) begin
                n_packet_time = i_timestamp;
                n_phase       = PH_TIME;
            end else begin
                n_phase = PH_IDLE;
            end
        end else begin
            case (r_phase)
                PH_TIME: begin
                    if (!high) begin
                        // Skip SysEx payload, otherwise drop the packet.
                        if (!r_in_sysex) n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    if (high) begin
                        if (i_byte == bmidi_pkg::ST_SYSEX_START ||
                            i_byte == bmidi_pkg::ST_SYSEX_END) begin
                            n_in_sysex = (i_byte == bmidi_pkg::ST_SYSEX_START);
                            n_running  = '0;
                            n_phase    = PH_TIME;
                        end else begin
                            if (i_byte < bmidi_pkg::ST_SYSEX_START) begin
                                n_running = i_byte;
                            end else if (i_byte < bmidi_pkg::ST_REALTIME) begin
                                n_running = '0;
                            end
                            n_current = i_byte;
                            n_needed  = len_byte;
                            n_taken   = 1'b0;
                            n_hold    = '0;
                            if (len_byte == 2'd0) begin
                                n_phase      = PH_TIME;
                                o_emit       = 1'b1;
                                o_msg.status = i_byte;
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end
                    end else if (r_running == '0) begin
                        n_phase = PH_IDLE;
                    end else begin
                        // Data byte under running status.
                        n_current = r_running;
                        n_needed  = len_running;
                        if (len_running <= 2'd1) begin
                            n_phase      = PH_TIME;
                            n_taken      = 1'b0;
                            o_emit       = 1'b1;
                            o_msg.status = r_running;
                            o_msg.data1  = i_byte[bmidi_pkg::DATA_W-1:0];
                            o_msg.count  = len_running;
                        end else begin
                            n_taken = 1'b1;
                            n_hold  = i_byte[bmidi_pkg::DATA_W-1:0];
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    if (high) begin
                        n_phase = PH_IDLE;
                    end else if (!r_taken) begin
                        if (r_needed <= 2'd1) begin
                            n_phase      = PH_TIME;
                            o_emit       = 1'b1;
                            o_msg.status = r_current;
                            o_msg.data1  = i_byte[bmidi_pkg::DATA_W-1:0];
                            o_msg.count  = r_needed;
                        end else begin
                            n_taken = 1'b1;
                            n_hold  = i_byte[bmidi_pkg::DATA_W-1:0];
                        end
                    end else begin
                        n_taken      = 1'b0;
                        n_phase      = PH_TIME;
                        o_emit       = 1'b1;
                        o_msg.status = r_current;
                        o_msg.data1  = r_hold;
                        o_msg.data2  = i_byte[bmidi_pkg::DATA_W-1:0];
                        o_msg.count  = 2'd2;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_running     <= '0;
            r_in_sysex    <= 1'b0;
            r_current     <= '0;
            r_needed      <= '0;
            r_taken       <= 1'b0;
            r_hold        <= '0;
            r_packet_time <= '0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_running     <= n_running;
            r_in_sysex    <= n_in_sysex;
            r_current     <= n_current;
            r_needed      <= n_needed;
            r_taken       <= n_taken;
            r_hold        <= n_hold;
            r_packet_time <= n_packet_time;
        end
    end

    // Running status only ever holds a channel voice status or zero.
    a_running_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running == '0 || (r_running[7] && r_running < bmidi_pkg::ST_SYSEX_START))
        else $error("running status outside channel range");

    // Waiting for data implies a status that takes data.
    a_data_needed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_needed != 2'd0)
        else $error("data phase without data length");

    // A held second byte only exists for two-byte messages.
    a_taken_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA && r_taken) |-> r_needed == 2'd2)
        else $error("held data byte for a short message");

endmodule

// ===== hdl/ble_midi_packet_decoder.sv =====
// Top level of the BLE MIDI packet decoder: input register, parser, result register.
// Depends on bmidi_pkg and bmidi_parser.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one packet byte per transfer,
//   with i_first_of_packet marking the header byte and i_timestamp_us the
//   packet time (latched from the header only).
//   Output channel (o_out_valid / i_out_ready) carries one complete MIDI
//   message per transfer: status, up to two data bytes, data count and the
//   timestamp of the packet the message came from.
//   Order: an accepted byte is parsed from the input register; its message,
//   if any, is loaded into the result register and offered from there.
//   Throughput: one byte per cycle while the result register is not stalled;
//   the parser state update is a single short decode between the input
//   register and the state and result registers.
//   Many bytes produce no message (headers, timestamps, first data bytes).
//   Reset: synchronous, active low; clears both valid flags, the parser goes
//   idle and waits for a packet header, running status and SysEx flag clear.
//   Stall: while a message waits in the result register and the receiver
//   holds i_out_ready low, the parser holds; an empty input register still
//   takes one byte, then o_in_ready drops until the result is taken.
module ble_midi_packet_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [bmidi_pkg::BYTE_W-1:0]     i_rx_byte,
    input  logic                             i_first_of_packet,
    input  logic [bmidi_pkg::TS_W-1:0]       i_timestamp_us,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bmidi_pkg::BYTE_W-1:0]     o_msg_status,
    output logic [bmidi_pkg::DATA_W-1:0]     o_msg_data1,
    output logic [bmidi_pkg::DATA_W-1:0]     o_msg_data2,
    output logic [bmidi_pkg::COUNT_W-1:0]    o_msg_data_count,
    output logic [bmidi_pkg::TS_W-1:0]       o_msg_timestamp_us
);

    // Input register
    logic                            r_in_valid;
    logic [bmidi_pkg::BYTE_W-1:0]    r_byte;
    logic                            r_first;
    logic [bmidi_pkg::TS_W-1:0]      r_timestamp;

    // Result register
    logic                            r_out_valid;
    bmidi_pkg::t_msg                 r_msg;

    logic                            advance;
    logic                            step;
    logic                            emit;
    bmidi_pkg::t_msg                 msg;

    // Result slot is free or being emptied this cycle: the parser may consume a byte.
    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Payload: load on each input transfer, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_byte      <= i_rx_byte;
            r_first     <= i_first_of_packet;
            r_timestamp <= i_timestamp_us;
        end
    end

    bmidi_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_byte),
        .i_first     (r_first),
        .i_timestamp (r_timestamp),
        .o_emit      (emit),
        .o_msg       (msg)
    );

    // Refill or drain the result register whenever it is free to move.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_msg <= msg;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_msg_status       = r_msg.status;
    assign o_msg_data1        = r_msg.data1;
    assign o_msg_data2        = r_msg.data2;
    assign o_msg_data_count   = r_msg.count;
    assign o_msg_timestamp_us = r_msg.timestamp;

    // A pending result always carries a real status byte.
    a_status_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_msg.status[bmidi_pkg::BYTE_W-1])
        else $error("result without status bit");

    // Unused data bytes read as zero and the count stays in range.
    a_count_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_msg.count != 2'd3) &&
                        (r_msg.count == 2'd2 || r_msg.data2 == '0) &&
                        (r_msg.count != 2'd0 || r_msg.data1 == '0))
        else $error("result data fill does not match count");

    // A stalled result blocks the parser, so a buffered byte stays put.
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |=> r_in_valid && $stable(r_byte))
        else $error("buffered byte lost during output stall");

    // A result is overwritten only after it has been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid && $stable(r_msg))
        else $error("pending result changed before transfer");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for ble_midi_packet_decoder: directed and random BLE MIDI packets.
// Predicts each message with its own byte decoder and compares every output transfer.
// Depends on bmidi_pkg and the ble_midi_packet_decoder RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int LONG_HOLD      = 300;   // receiver hold-off in the stall test
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transfer on either side
    localparam int DRAIN_CYCLES   = 10;    // wait after the final drain for any stray message
    localparam int RANDOM_END     = 1200;  // bytes sent when the random phase stops
    localparam int STEADY_BYTES   = 200;

    // Status codes that the package leaves unnamed.
    localparam logic [bmidi_pkg::BYTE_W-1:0] ST_TUNE_REQUEST = 8'hf6;
    localparam logic [bmidi_pkg::BYTE_W-1:0] ST_SYS_RESET    = 8'hff;

    typedef logic [bmidi_pkg::TS_W-1:0] t_word;

    // DUT inputs start at known values.
    logic                          i_clk             = 1'b0;
    logic                          i_rst_n           = 1'b0;
    logic                          i_in_valid        = 1'b0;
    logic [bmidi_pkg::BYTE_W-1:0]  i_rx_byte         = '0;
    logic                          i_first_of_packet = 1'b0;
    logic [bmidi_pkg::TS_W-1:0]    i_timestamp_us    = '0;
    logic                          i_out_ready       = 1'b0;

    logic                           o_in_ready;
    logic                           o_out_valid;
    logic [bmidi_pkg::BYTE_W-1:0]   o_msg_status;
    logic [bmidi_pkg::DATA_W-1:0]   o_msg_data1;
    logic [bmidi_pkg::DATA_W-1:0]   o_msg_data2;
    logic [bmidi_pkg::COUNT_W-1:0]  o_msg_data_count;
    logic [bmidi_pkg::TS_W-1:0]     o_msg_timestamp_us;

    ble_midi_packet_decoder DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_rx_byte          (i_rx_byte),
        .i_first_of_packet  (i_first_of_packet),
        .i_timestamp_us     (i_timestamp_us),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_msg_status       (o_msg_status),
        .o_msg_data1        (o_msg_data1),
        .o_msg_data2        (o_msg_data2),
        .o_msg_data_count   (o_msg_data_count),
        .o_msg_timestamp_us (o_msg_timestamp_us)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Message predictor: a byte-level copy of the packet parser state.
    // ------------------------------------------------------------------
    typedef enum logic [1:0] {
        AWAIT_NONE,    // idle, or the packet was dropped
        AWAIT_TSTAMP,  // next byte must be a message timestamp
        AWAIT_STATUS,  // status byte, or a data byte under running status
        AWAIT_DATA     // data bytes of the current message
    } t_scan;

    t_scan                          scan        = AWAIT_NONE;
    logic [bmidi_pkg::BYTE_W-1:0]   running_st  = '0;
    logic                           sysex_open  = 1'b0;
    logic [bmidi_pkg::BYTE_W-1:0]   cur_st      = '0;
    logic [bmidi_pkg::COUNT_W-1:0]  need        = '0;
    logic [bmidi_pkg::COUNT_W-1:0]  taken       = '0;
    logic [bmidi_pkg::DATA_W-1:0]   held        = '0;
    logic [bmidi_pkg::TS_W-1:0]     pkt_ts      = '0;

    bmidi_pkg::t_msg pending_msgs[$];   // predicted messages not yet seen on the output
    int   error_count = 0;
    int   bytes_sent  = 0;

    // Handshake and idling controls shared between the test tasks, the sender and the sink.
    bit src_idle_en   = 1'b0;
    bit sink_idle_en  = 1'b0;
    bit sink_hold_req = 1'b0;

    // Data bytes that follow a status byte; only called with bit 7 set.
    function automatic logic [bmidi_pkg::COUNT_W-1:0] data_len(
        input logic [bmidi_pkg::BYTE_W-1:0] st);
        case (st & bmidi_pkg::CMD_MASK)
            bmidi_pkg::ST_PROG_CHANGE, bmidi_pkg::ST_CHAN_PRESS: return 2'd1;
            bmidi_pkg::ST_SYSEX_START: begin
                if (st == bmidi_pkg::ST_TIME_CODE || st == bmidi_pkg::ST_SONG_SELECT)
                    return 2'd1;
                return (st == bmidi_pkg::ST_SONG_POS) ? 2'd2 : 2'd0;
            end
            default: return 2'd2;
        endcase
    endfunction

    function automatic void queue_msg(input logic [bmidi_pkg::BYTE_W-1:0] st,
                                      input logic [bmidi_pkg::DATA_W-1:0] d1,
                                      input logic [bmidi_pkg::DATA_W-1:0] d2,
                                      input logic [bmidi_pkg::COUNT_W-1:0] n);
        bmidi_pkg::t_msg m;
        m.status    = st;
        m.data1     = d1;
        m.data2     = d2;
        m.count     = n;
        m.timestamp = pkt_ts;
        pending_msgs.push_back(m);
    endfunction

    // Advance the predicted parser by one accepted byte.
    function automatic void decode_byte(input logic [bmidi_pkg::BYTE_W-1:0] b,
                                        input logic first,
                                        input logic [bmidi_pkg::TS_W-1:0] ts);
        logic high;
        high = b[7];
        if (first) begin
            // A header always discards an unfinished message.
            taken = '0;
            held  = '0;
            if (high) begin
                pkt_ts = ts;
                scan   = AWAIT_TSTAMP;
            end else begin
                scan = AWAIT_NONE;
            end
            return;
        end
        case (scan)
            AWAIT_TSTAMP: begin
                // Inside SysEx, skip data bytes found in place of a timestamp.
                if (high) scan = AWAIT_STATUS;
                else if (!sysex_open) scan = AWAIT_NONE;
            end
            AWAIT_STATUS: begin
                if (high) begin
                    if (b == bmidi_pkg::ST_SYSEX_START || b == bmidi_pkg::ST_SYSEX_END) begin
                        sysex_open = (b == bmidi_pkg::ST_SYSEX_START);
                        running_st = '0;
                        scan       = AWAIT_TSTAMP;
                    end else begin
                        if (b < bmidi_pkg::ST_SYSEX_START) running_st = b;
                        else if (b < bmidi_pkg::ST_REALTIME) running_st = '0;
                        cur_st = b;
                        need   = data_len(b);
                        taken  = '0;
                        held   = '0;
                        if (need == 0) begin
                            scan = AWAIT_TSTAMP;
                            queue_msg(b, '0, '0, '0);
                        end else begin
                            scan = AWAIT_DATA;
                        end
                    end
                end else if (running_st == '0) begin
                    scan = AWAIT_NONE;
                end else begin
                    cur_st = running_st;
                    need   = data_len(running_st);
                    if (need <= 1) begin
                        scan  = AWAIT_TSTAMP;
                        taken = '0;
                        queue_msg(cur_st, b[bmidi_pkg::DATA_W-1:0], '0, need);
                    end else begin
                        taken = 2'd1;
                        held  = b[bmidi_pkg::DATA_W-1:0];
                        scan  = AWAIT_DATA;
                    end
                end
            end
            AWAIT_DATA: begin
                if (high) begin
                    scan = AWAIT_NONE;
                end else if (taken == 0) begin
                    if (need <= 1) begin
                        scan = AWAIT_TSTAMP;
                        queue_msg(cur_st, b[bmidi_pkg::DATA_W-1:0], '0, need);
                    end else begin
                        taken = 2'd1;
                        held  = b[bmidi_pkg::DATA_W-1:0];
                    end
                end else begin
                    taken = '0;
                    scan  = AWAIT_TSTAMP;
                    queue_msg(cur_st, held, b[bmidi_pkg::DATA_W-1:0], 2'd2);
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    function automatic logic [bmidi_pkg::TS_W-1:0] rand_ts();
        return {$urandom, $urandom};
    endfunction

    // Offer one byte and hold it until the transfer; predict on acceptance.
    task automatic send_byte(input logic [bmidi_pkg::BYTE_W-1:0] b, input logic first,
                             input logic [bmidi_pkg::TS_W-1:0] ts);
        int gap;
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_rx_byte         <= b;
        i_first_of_packet <= first;
        i_timestamp_us    <= ts;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        decode_byte(b, first, ts);
        bytes_sent++;
    endtask

    // Body byte of a packet; the timestamp input is don't-care here, so randomize it.
    task automatic send_body(input logic [bmidi_pkg::BYTE_W-1:0] b);
        send_byte(b, 1'b0, rand_ts());
    endtask

    task automatic send_header();
        send_byte(8'($urandom_range(128, 255)), 1'b1, rand_ts());
    endtask

    task automatic send_tstamp();
        send_body(8'($urandom_range(128, 255)));
    endtask

    // Data bytes; a noisy byte may carry bit 7 and drop the packet.
    task automatic send_data(input int n, input bit noisy);
        for (int k = 0; k < n; k++) begin
            if (noisy && $urandom_range(0, 7) == 0) send_body(8'($urandom_range(0, 255)));
            else send_body(8'($urandom_range(0, 127)));
        end
    endtask

    // Stop offering and wait until every predicted message has come out.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_msgs.size() != 0);
    endtask

    // One message after its timestamp: mostly well formed, with random content.
    task automatic send_random_message(input bit noisy);
        logic [bmidi_pkg::BYTE_W-1:0] st;
        int                           form;
        if (noisy && $urandom_range(0, 9) == 0) send_body(8'($urandom_range(0, 127)));
        else send_tstamp();
        form = $urandom_range(0, 9);
        case (form)
            4: begin
                // running status: data bytes only
                send_data((running_st != '0) ? int'(data_len(running_st))
                                             : $urandom_range(1, 2), noisy);
            end
            5: begin
                st = 8'($urandom_range(bmidi_pkg::ST_TIME_CODE, ST_TUNE_REQUEST));
                send_body(st);
                send_data(int'(data_len(st)), noisy);
            end
            6: send_body(8'($urandom_range(bmidi_pkg::ST_REALTIME, ST_SYS_RESET)));
            7: begin
                send_body(bmidi_pkg::ST_SYSEX_START);
                send_data($urandom_range(0, 4), noisy);
                // carry the SysEx over into the next packet now and then
                if ($urandom_range(0, 2) == 0) begin
                    send_header();
                    send_data($urandom_range(0, 3), noisy);
                end
                send_tstamp();
                send_body(bmidi_pkg::ST_SYSEX_END);
            end
            default: begin
                st = 8'($urandom_range(bmidi_pkg::ST_CHANNEL_BASE,
                                       bmidi_pkg::ST_SYSEX_START - 1));
                send_body(st);
                // truncate now and then so that the next header lands mid-message
                if (noisy && $urandom_range(0, 7) == 0) send_data(int'(data_len(st)) - 1, 1'b0);
                else send_data(int'(data_len(st)), noisy);
            end
        endcase
    endtask

    task automatic send_random_packet();
        bit noisy;
        noisy = ($urandom_range(0, 3) == 0);
        if (noisy && $urandom_range(0, 3) == 0) send_body(8'($urandom_range(0, 255)));
        if (noisy && $urandom_range(0, 5) == 0) send_byte(8'($urandom_range(0, 127)), 1'b1,
                                                          rand_ts());
        else send_header();
        repeat ($urandom_range(1, 5)) send_random_message(noisy);
    endtask

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // Headers, packet drops and bytes outside any packet.
    task automatic test_packet_framing();
        send_body(8'h00);                      // outside a packet: ignored
        send_byte(8'h7f, 1'b1, rand_ts());     // header without bit 7: drop the packet
        send_body(bmidi_pkg::ST_CHANNEL_BASE); // still dropped
        send_byte(8'h80, 1'b1, '0);            // smallest header, zero time
        send_body(8'h80);
        send_body(8'h05);                      // data with no running status: drop
    endtask

    // Channel messages, running status and the extremes of the data bytes.
    task automatic test_channel_messages();
        send_byte(8'hff, 1'b1, '1);            // largest header, all-ones time
        send_body(8'hff);
        send_body(bmidi_pkg::ST_CHANNEL_BASE | 8'h10);
        send_body(8'h00);
        send_body(8'h7f);
        send_tstamp();
        send_body(8'h12);                      // reuse note-on running status
        send_body(8'h34);
        send_tstamp();
        send_body(bmidi_pkg::ST_PROG_CHANGE | 8'h05);
        send_body(8'h7f);
        send_tstamp();
        send_body(8'h05);                      // one-byte running status
    endtask

    // Real-time, system common and SysEx handling of running status.
    task automatic test_system_messages();
        send_tstamp();
        send_body(bmidi_pkg::ST_REALTIME);     // keeps running status
        send_tstamp();
        send_body(8'h22);
        send_tstamp();
        send_body(bmidi_pkg::ST_SYSEX_START);
        send_body(8'h11);                      // skipped inside SysEx
        send_tstamp();
        send_body(bmidi_pkg::ST_SYSEX_END);
        send_tstamp();
        send_body(bmidi_pkg::ST_SONG_POS);
        send_body(8'h01);
        send_body(8'h02);
        send_tstamp();
        send_body(bmidi_pkg::ST_TIME_CODE);
        send_body(8'h03);
        send_tstamp();
        send_body(ST_TUNE_REQUEST);
        send_tstamp();
        send_body(ST_SYS_RESET);
        send_tstamp();
        send_body(8'h10);                      // running status was cleared: drop
    endtask

    // Status byte where data is due, and a new header in the middle of a message.
    task automatic test_broken_messages();
        send_header();
        send_tstamp();
        send_body(bmidi_pkg::ST_PITCH_BEND | 8'h03);
        send_body(8'h01);
        send_body(bmidi_pkg::ST_CHANNEL_BASE | 8'h10);  // status in place of data: drop
        send_header();
        send_tstamp();
        send_body(bmidi_pkg::ST_CTRL_CHANGE | 8'h01);
        send_body(8'h01);
        send_header();                         // discard the half message
        send_tstamp();
        send_body(8'h02);
        send_body(8'h03);
    endtask

    // Hold the receiver off for a long stretch while bytes keep coming.
    task automatic test_output_stall();
        sink_hold_req = 1'b1;
        send_header();
        repeat (12) begin
            send_tstamp();
            send_body(8'($urandom_range(bmidi_pkg::ST_REALTIME, ST_SYS_RESET)));
        end
        wait_for_drain();
    endtask

    // Pause the sender until the block has emptied, then resume.
    task automatic test_sender_pause();
        send_random_packet();
        wait_for_drain();
        send_random_packet();
    endtask

    task automatic test_random_traffic();
        int packets;
        packets = 0;
        while (bytes_sent < RANDOM_END) begin
            // re-pick idling every few packets, so quiet stretches occur as well
            if (packets % 8 == 0) begin
                src_idle_en  = ($urandom_range(0, 3) != 0);
                sink_idle_en = ($urandom_range(0, 3) != 0);
            end
            send_random_packet();
            packets++;
        end
    endtask

    task automatic test_steady_stream();
        int target;
        target = bytes_sent + STEADY_BYTES;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        while (bytes_sent < target) send_random_packet();
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts plus the requested long hold-off.
    // ------------------------------------------------------------------
    int unsigned sink_wait = 0;

    always @(posedge i_clk) begin
        if (sink_hold_req) begin
            sink_hold_req = 1'b0;
            sink_wait     = LONG_HOLD;
        end
        if (sink_wait > 0) begin
            sink_wait--;
            i_out_ready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            sink_wait = $urandom_range(1, 11) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare each output transfer with the oldest prediction.
    // ------------------------------------------------------------------
    function automatic void check_field(input string what, input t_word want,
                                        input t_word got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, what, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : compare_msgs
        bmidi_pkg::t_msg want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_msgs.size() == 0) begin
                $display("%0t: unexpected message, expected none, actual status %0h",
                         $realtime, o_msg_status);
                error_count++;
            end else begin
                want = pending_msgs.pop_front();
                check_field("status", t_word'(want.status), t_word'(o_msg_status));
                check_field("data1", t_word'(want.data1), t_word'(o_msg_data1));
                check_field("data2", t_word'(want.data2), t_word'(o_msg_data2));
                check_field("data count", t_word'(want.count), t_word'(o_msg_data_count));
                check_field("timestamp", want.timestamp, o_msg_timestamp_us);
            end
        end
    end

    // Watchdog: end the run if neither side transfers for too long.
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d messages outstanding",
                         $realtime, quiet_cycles, pending_msgs.size());
                $display("ble_midi_packet_decoder test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_packet_framing();
        test_channel_messages();
        test_system_messages();
        test_broken_messages();
        wait_for_drain();

        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        test_output_stall();
        test_sender_pause();
        test_random_traffic();
        test_steady_stream();

        // Drain, then wait out DRAIN_CYCLES for any stray message.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("ble_midi_packet_decoder test passed");
        end else begin
            $display("ble_midi_packet_decoder test failed");
        end
        $finish;
    end

endmodule
